[design/b64d_pkg.sv]
// Shared types, status codes and the alphabet lookup for the Base64 stream decoder.
`timescale 1ns / 1ps
`default_nettype none

package b64d_pkg;

    localparam int unsigned CHAR_W   = 8;
    localparam int unsigned SEXTET_W = 6;
    localparam int unsigned MAX_RES  = 3;

    localparam logic [CHAR_W-1:0] PAD_CHAR = 8'h3D;

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_BAD_CHR = 2'd1,
        STATUS_BAD_LEN = 2'd2
    } status_t;

    // One result request as it waits in the output buffer.
    typedef struct packed {
        logic [CHAR_W-1:0] data_byte;
        logic              byte_valid;
        logic              end_of_string;
        status_t           status;
    } result_t;

    // Alphabet lookup: sextet value plus a flag for characters outside it.
    typedef struct packed {
        logic                bad;
        logic [SEXTET_W-1:0] value;
    } sextet_t;

    function automatic sextet_t sextet_of(input logic [CHAR_W-1:0] c);
        sextet_t s;
        s.bad   = 1'b0;
        s.value = '0;
        if (c >= 8'h41 && c <= 8'h5A) begin
            s.value = SEXTET_W'(c - 8'h41);
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            s.value = SEXTET_W'(c - 8'h61 + 8'd26);
        end else if (c >= 8'h30 && c <= 8'h39) begin
            s.value = SEXTET_W'(c - 8'h30 + 8'd52);
        end else if (c == 8'h2B) begin
            s.value = 6'd62;
        end else if (c == 8'h2F) begin
            s.value = 6'd63;
        end else begin
            s.bad = 1'b1;
        end
        return s;
    endfunction

endpackage

`default_nettype wire

[design/base64_stream_decoder_unit.sv]
// Top level of the Base64 stream decoder: group tracking, decode and result buffer.
`timescale 1ns / 1ps
`default_nettype none

// A character's first result is registered and shows in the next cycle.
// Flow: one character per cycle while s_ready is high; a closing group drains up to
// three bytes, one per cycle while m_ready is high, and the next character is taken
// while the last of them is taken. Stall: any character waits while two or more
// results are pending, or while one is pending and m_ready is low.
// Reset (aresetn low, synchronous) clears group position, error status and buffer.
module base64_stream_decoder_unit (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire logic [7:0]             s_char_in,
    input  wire logic                   s_last_char,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output logic [7:0]                  m_data_byte,
    output logic                        m_byte_valid,
    output logic                        m_end_of_string,
    output logic [1:0]                  m_status
);
    import b64d_pkg::*;

    // Group state: position in the group of four and first error of the string.
    logic [1:0]        pos_reg, pos_next;
    status_t           err_reg, err_next;
    // First three characters of the current group (no reset; always written first).
    logic [CHAR_W-1:0] held_reg [MAX_RES];

    // Result buffer: entries loaded in one go, drained from head.
    result_t           res_reg  [MAX_RES];
    result_t           res_next [MAX_RES];
    logic [1:0]        head_reg, head_next;
    logic [1:0]        cnt_reg,  cnt_next;
    logic [1:0]        n_res;

    logic              acc_in;
    logic              pop_out;

    // Decode signals for a closing group.
    sextet_t           sx0, sx1, sx2, sx3;
    logic [1:0]        byte_cnt;
    logic              bad;
    logic [CHAR_W-1:0] b0, b1, b2;

    assign m_valid = (cnt_reg != 2'd0);
    assign pop_out = m_valid && m_ready;
    // Take a new request when the buffer is empty or empties this cycle.
    assign s_ready = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && m_ready);
    assign acc_in  = s_valid && s_ready;

    assign m_data_byte     = res_reg[head_reg].data_byte;
    assign m_byte_valid    = res_reg[head_reg].byte_valid;
    assign m_end_of_string = res_reg[head_reg].end_of_string;
    assign m_status        = res_reg[head_reg].status;

    // Map all four characters; padding decides how many of them count.
    always_comb begin
        sx0 = sextet_of(held_reg[0]);
        sx1 = sextet_of(held_reg[1]);
        sx2 = sextet_of(held_reg[2]);
        sx3 = sextet_of(s_char_in);

        if (s_last_char && held_reg[2] == PAD_CHAR) begin
            byte_cnt = 2'd1;
        end else if (s_last_char && s_char_in == PAD_CHAR) begin
            byte_cnt = 2'd2;
        end else begin
            byte_cnt = 2'd3;
        end

        bad = sx0.bad || sx1.bad
            || (byte_cnt != 2'd1 && sx2.bad)
            || (byte_cnt == 2'd3 && sx3.bad);

        // Pack sextets into bytes; unused trailing bits are dropped unchecked.
        b0 = {sx0.value, sx1.value[5:4]};
        b1 = {sx1.value[3:0], sx2.value[5:2]};
        b2 = {sx2.value[1:0], sx3.value};
    end

    // Next state of the group tracker and the contents to load into the buffer.
    always_comb begin
        pos_next  = pos_reg;
        err_next  = err_reg;
        n_res     = 2'd0;
        for (int i = 0; i < MAX_RES; i++) begin
            res_next[i] = '{data_byte: '0, byte_valid: 1'b0,
                            end_of_string: 1'b0, status: STATUS_OK};
        end

        if (pos_reg != 2'd3) begin
            // Still gathering: advance, or close a short string with a length error.
            pos_next = pos_reg + 2'd1;
            if (s_last_char) begin
                res_next[0].end_of_string = 1'b1;
                res_next[0].status        = STATUS_BAD_LEN;
                n_res    = 2'd1;
                pos_next = 2'd0;
                err_next = STATUS_OK;
            end
        end else begin
            pos_next = 2'd0;
            if (err_reg == STATUS_OK && !bad) begin
                res_next[0].data_byte  = b0;
                res_next[0].byte_valid = 1'b1;
                res_next[1].data_byte  = b1;
                res_next[1].byte_valid = 1'b1;
                res_next[2].data_byte  = b2;
                res_next[2].byte_valid = 1'b1;
                // Flag the final byte of the string.
                case (byte_cnt)
                    2'd1:    res_next[0].end_of_string = s_last_char;
                    2'd2:    res_next[1].end_of_string = s_last_char;
                    default: res_next[2].end_of_string = s_last_char;
                endcase
                n_res = byte_cnt;
            end else begin
                // Record the first error; report it on the last character.
                if (err_reg == STATUS_OK) begin
                    err_next = STATUS_BAD_CHR;
                end
                if (s_last_char) begin
                    res_next[0].end_of_string = 1'b1;
                    res_next[0].status        = (err_reg == STATUS_OK) ? STATUS_BAD_CHR
                                                                       : err_reg;
                    n_res    = 2'd1;
                    err_next = STATUS_OK;
                end
            end
        end
    end

    // Buffer pointers: load on a new request, otherwise drain.
    always_comb begin
        head_next = head_reg;
        cnt_next  = cnt_reg;
        if (acc_in) begin
            head_next = 2'd0;
            cnt_next  = n_res;
        end else if (pop_out) begin
            head_next = head_reg + 2'd1;
            cnt_next  = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg  <= 2'd0;
            err_reg  <= STATUS_OK;
            head_reg <= 2'd0;
            cnt_reg  <= 2'd0;
        end else begin
            head_reg <= head_next;
            cnt_reg  <= cnt_next;
            if (acc_in) begin
                pos_reg <= pos_next;
                err_reg <= err_next;
            end
        end
    end

    // Payload registers: hold characters of the group and the loaded results.
    always_ff @(posedge aclk) begin
        if (acc_in) begin
            case (pos_reg)
                2'd0:    held_reg[0] <= s_char_in;
                2'd1:    held_reg[1] <= s_char_in;
                2'd2:    held_reg[2] <= s_char_in;
                default: ;
            endcase
            for (int i = 0; i < MAX_RES; i++) begin
                res_reg[i] <= res_next[i];
            end
        end
    end

endmodule

`default_nettype wire
